// ===== sv/bmh_pkg.sv =====
// bmh_pkg: shared types, sizes and binning constants for the binned mass histogram.
// Used by every module of the block except bmh_ram; depends on nothing.

package bmh_pkg;

   localparam int PT_BIN_COUNT   = 11;
   localparam int MASS_BIN_COUNT = 50;
   localparam int COUNTER_WIDTH  = 32;

   localparam int PT_LOW_MEV     = 2500;
   localparam int PT_STEP_MEV    = 500;
   localparam int MASS_STEP_MEV  = 30;
   localparam int PT_HIGH_MEV    = PT_LOW_MEV + PT_STEP_MEV * PT_BIN_COUNT;
   localparam int MASS_LIMIT_MEV = MASS_STEP_MEV * MASS_BIN_COUNT;

   localparam int MASS_SLOTS     = MASS_BIN_COUNT + 1;
   localparam int ROW_COUNT      = 2 * PT_BIN_COUNT;
   localparam int STORE_DEPTH    = ROW_COUNT * MASS_SLOTS;
   localparam int ADDR_WIDTH     = $clog2(STORE_DEPTH);
   localparam int ROW_WIDTH      = $clog2(ROW_COUNT + 1);

   localparam int PT_WIDTH       = 16;
   localparam int MASS_WIDTH     = 16;
   localparam int SECTOR_WIDTH   = 3;
   localparam int PT_BIN_WIDTH   = 4;
   localparam int MASS_BIN_WIDTH = 6;
   localparam int COUNT_WIDTH    = 32;

   // Constant division by reciprocal multiply: q = (x * RECIP) >> SHIFT
   localparam int PT_OFF_WIDTH    = $clog2(PT_HIGH_MEV - PT_LOW_MEV);
   localparam int PT_RECIP_SHIFT  = 24;
   localparam int PT_RECIP        = ((1 << PT_RECIP_SHIFT) + PT_STEP_MEV - 1) / PT_STEP_MEV;
   localparam int PT_RECIP_WIDTH  = $clog2(PT_RECIP + 1);
   localparam int PT_PROD_WIDTH   = PT_OFF_WIDTH + PT_RECIP_WIDTH;

   localparam int MASS_IN_WIDTH    = $clog2(MASS_LIMIT_MEV + 1);
   localparam int MASS_RECIP_SHIFT = 20;
   localparam int MASS_RECIP       = ((1 << MASS_RECIP_SHIFT) + MASS_STEP_MEV - 1)
                                     / MASS_STEP_MEV;
   localparam int MASS_RECIP_WIDTH = $clog2(MASS_RECIP + 1);
   localparam int MASS_PROD_WIDTH  = MASS_IN_WIDTH + MASS_RECIP_WIDTH;

   localparam int CSR_ADDR_WIDTH      = 3;
   localparam int CSR_DATA_WIDTH      = 32;
   localparam int CFG_REG_LAST_SECTOR = 0;
   localparam int LAST_SECTOR_RESET   = 5;

   localparam logic CMD_FILL = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic                      command;
      logic [PT_WIDTH-1:0]       pt_mev;
      logic [MASS_WIDTH-1:0]     mass_mev;
      logic [SECTOR_WIDTH-1:0]   sector;
      logic                      min_bias_fired;
      logic                      read_class;
      logic [PT_BIN_WIDTH-1:0]   read_pt_bin;
      logic [MASS_BIN_WIDTH-1:0] read_mass_bin;
   } req_type;

   typedef struct packed {
      logic                      counted;
      logic [COUNT_WIDTH-1:0]    bin_count;
      logic                      class_out;
      logic [PT_BIN_WIDTH-1:0]   pt_bin_out;
      logic [MASS_BIN_WIDTH-1:0] mass_bin_out;
   } rsp_type;

   typedef struct packed {
      logic clear_en;
      logic capture;
      logic bin_en;
      logic addr_en;
      logic ram_read;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic out_free;
   } status_type;

endpackage

// ===== sv/bmh_ram.sv =====
// bmh_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module bmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bmh_ctrl.sv =====
// bmh_ctrl: sequencer for the histogram block (clear pass, then one item at a time).
// Depends on bmh_pkg for the command and status structs.

module bmh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bmh_pkg::status_type    status,
   output bmh_pkg::cmd_type       cmd
);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_BIN    = 6'b000100,
      S_ADDR   = 6'b001000,
      S_READ   = 6'b010000,
      S_UPDATE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_BIN;
            end
         end
         S_BIN: begin
            cmd.bin_en = 1'b1;
            state_in   = S_ADDR;
         end
         S_ADDR: begin
            cmd.addr_en = 1'b1;
            state_in    = S_READ;
         end
         S_READ: begin
            cmd.ram_read = 1'b1;
            state_in     = S_UPDATE;
         end
         S_UPDATE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/bmh_datapath.sv =====
// bmh_datapath: binning multipliers, counter address, counter store and result register.
// Depends on bmh_pkg and bmh_ram.

module bmh_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bmh_pkg::cmd_type                  cmd,
   output bmh_pkg::status_type               status,
   input  logic [bmh_pkg::SECTOR_WIDTH-1:0]  last_sector,
   input  bmh_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bmh_pkg::rsp_type                  rsp_data
);

   bmh_pkg::req_type                            item_ff, item_in;

   logic                                        keep_ff, keep_in;
   logic                                        cls_ff, cls_in;
   logic                                        under_ff, under_in;
   logic [bmh_pkg::PT_PROD_WIDTH-1:0]           pt_prod_ff, pt_prod_in;
   logic [bmh_pkg::MASS_PROD_WIDTH-1:0]         mass_prod_ff, mass_prod_in;

   logic [bmh_pkg::ADDR_WIDTH-1:0]              addr_ff, addr_in;
   logic                                        hit_ff, hit_in;
   logic                                        class_ff, class_in;
   logic [bmh_pkg::PT_BIN_WIDTH-1:0]            pt_bin_ff, pt_bin_in;
   logic [bmh_pkg::MASS_BIN_WIDTH-1:0]          mass_bin_ff, mass_bin_in;

   logic [bmh_pkg::ADDR_WIDTH-1:0]              clear_cnt_ff, clear_cnt_in;
   logic                                        rsp_valid_ff, rsp_valid_in;
   bmh_pkg::rsp_type                            rsp_data_ff, rsp_data_in;

   logic [bmh_pkg::PT_OFF_WIDTH-1:0]            pt_off;
   logic [bmh_pkg::ROW_WIDTH-1:0]               row;
   logic [bmh_pkg::COUNTER_WIDTH-1:0]           cur_count;
   logic [bmh_pkg::COUNTER_WIDTH-1:0]           next_count;
   logic                                        saturated;
   logic                                        is_fill;

   logic                                        ram_wr_en;
   logic [bmh_pkg::ADDR_WIDTH-1:0]              ram_wr_addr;
   logic [bmh_pkg::COUNTER_WIDTH-1:0]           ram_wr_data;
   logic                                        ram_rd_en;

   assign is_fill = (item_ff.command == bmh_pkg::CMD_FILL);

   // bin stage: cuts, class and reciprocal products
   assign item_in = cmd.capture ? req_data : item_ff;
   assign pt_off  = bmh_pkg::PT_OFF_WIDTH'(item_ff.pt_mev
                                           - bmh_pkg::PT_WIDTH'(bmh_pkg::PT_LOW_MEV));

   always_comb begin
      keep_in      = keep_ff;
      cls_in       = cls_ff;
      under_in     = under_ff;
      pt_prod_in   = pt_prod_ff;
      mass_prod_in = mass_prod_ff;
      if (cmd.bin_en) begin
         keep_in = item_ff.min_bias_fired
                   && (item_ff.pt_mev >= bmh_pkg::PT_WIDTH'(bmh_pkg::PT_LOW_MEV))
                   && ({1'b0, item_ff.pt_mev}
                       < (bmh_pkg::PT_WIDTH + 1)'(bmh_pkg::PT_HIGH_MEV));
         cls_in   = (item_ff.sector > last_sector);
         under_in = (item_ff.mass_mev < bmh_pkg::MASS_WIDTH'(bmh_pkg::MASS_LIMIT_MEV));
         pt_prod_in = bmh_pkg::PT_PROD_WIDTH'(pt_off)
                      * bmh_pkg::PT_PROD_WIDTH'(bmh_pkg::PT_RECIP);
         mass_prod_in = bmh_pkg::MASS_PROD_WIDTH'(
                           item_ff.mass_mev[bmh_pkg::MASS_IN_WIDTH-1:0])
                        * bmh_pkg::MASS_PROD_WIDTH'(bmh_pkg::MASS_RECIP);
      end
   end

   // address stage: final bins and counter address
   always_comb begin
      class_in    = class_ff;
      pt_bin_in   = pt_bin_ff;
      mass_bin_in = mass_bin_ff;
      hit_in      = hit_ff;
      addr_in     = addr_ff;
      row         = '0;
      if (cmd.addr_en) begin
         if (is_fill) begin
            class_in  = cls_ff;
            pt_bin_in = pt_prod_ff[bmh_pkg::PT_RECIP_SHIFT +: bmh_pkg::PT_BIN_WIDTH];
            mass_bin_in = under_ff
               ? mass_prod_ff[bmh_pkg::MASS_RECIP_SHIFT +: bmh_pkg::MASS_BIN_WIDTH]
               : bmh_pkg::MASS_BIN_WIDTH'(bmh_pkg::MASS_BIN_COUNT);
            hit_in = keep_ff;
         end else begin
            class_in    = item_ff.read_class;
            pt_bin_in   = item_ff.read_pt_bin;
            mass_bin_in = item_ff.read_mass_bin;
            hit_in = ({1'b0, item_ff.read_pt_bin}
                      < (bmh_pkg::PT_BIN_WIDTH + 1)'(bmh_pkg::PT_BIN_COUNT))
                     && ({1'b0, item_ff.read_mass_bin}
                         <= (bmh_pkg::MASS_BIN_WIDTH + 1)'(bmh_pkg::MASS_BIN_COUNT));
         end
         row = bmh_pkg::ROW_WIDTH'(bmh_pkg::ROW_WIDTH'(class_in)
                                   * bmh_pkg::ROW_WIDTH'(bmh_pkg::PT_BIN_COUNT)
                                   + bmh_pkg::ROW_WIDTH'(pt_bin_in));
         addr_in = bmh_pkg::ADDR_WIDTH'(bmh_pkg::ADDR_WIDTH'(row)
                                        * bmh_pkg::ADDR_WIDTH'(bmh_pkg::MASS_SLOTS)
                                        + bmh_pkg::ADDR_WIDTH'(mass_bin_in));
      end
   end

   // update stage: saturating increment and result
   assign saturated  = (cur_count == '1);
   assign next_count = saturated ? cur_count : cur_count + 1'b1;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.finish) begin
         rsp_data_in = '0;
         if (!is_fill) begin
            rsp_data_in.bin_count    = hit_ff ? bmh_pkg::COUNT_WIDTH'(cur_count) : '0;
            rsp_data_in.class_out    = class_ff;
            rsp_data_in.pt_bin_out   = pt_bin_ff;
            rsp_data_in.mass_bin_out = mass_bin_ff;
         end else if (hit_ff) begin
            rsp_data_in.counted      = !saturated;
            rsp_data_in.bin_count    = bmh_pkg::COUNT_WIDTH'(next_count);
            rsp_data_in.class_out    = class_ff;
            rsp_data_in.pt_bin_out   = pt_bin_ff;
            rsp_data_in.mass_bin_out = mass_bin_ff;
         end
      end
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign clear_cnt_in = cmd.clear_en ? clear_cnt_ff + 1'b1 : clear_cnt_ff;

   always_comb begin
      if (cmd.clear_en) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clear_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = cmd.finish && is_fill && hit_ff && !saturated;
         ram_wr_addr = addr_ff;
         ram_wr_data = next_count;
      end
   end

   assign ram_rd_en = cmd.ram_read && hit_ff;

   bmh_ram #(
      .WIDTH (bmh_pkg::COUNTER_WIDTH),
      .DEPTH (bmh_pkg::STORE_DEPTH)
   ) u_counters (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (addr_ff),
      .rd_data (cur_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      keep_ff      <= keep_in;
      cls_ff       <= cls_in;
      under_ff     <= under_in;
      pt_prod_ff   <= pt_prod_in;
      mass_prod_ff <= mass_prod_in;
      addr_ff      <= addr_in;
      hit_ff       <= hit_in;
      class_ff     <= class_in;
      pt_bin_ff    <= pt_bin_in;
      mass_bin_ff  <= mass_bin_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign status.clear_done = (clear_cnt_ff == bmh_pkg::ADDR_WIDTH'(bmh_pkg::STORE_DEPTH - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

endmodule

// ===== sv/binned_mass_histogram_unit.sv =====
// binned_mass_histogram_unit: top level with the configuration register.
// Depends on bmh_pkg, bmh_ctrl, bmh_datapath (and bmh_ram through it).

// Fills a two-class, pt by mass histogram of saturating counters from pair
// candidates, or reads one counter back; every item gives one result item.
// After reset all 1122 counters of the store are cleared, one counter per
// cycle, during which req_ready stays low; the CSR port works throughout.
// Each item then steps through the controller states: accept/capture,
// the two reciprocal multipliers for the pt and mass bins, the address
// multiply, the counter RAM read, and the update/write-back into the result
// register. The next item is accepted only once the update step is done.
// The update step stalls while an older result is still waiting.
// One item is in flight at a time; a finished result waits in its output
// register while the next item is accepted. first_class_last_sector sits at
// byte address 0 and should be written only while the block is idle.

module binned_mass_histogram_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bmh_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bmh_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [bmh_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [bmh_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [bmh_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   logic [bmh_pkg::SECTOR_WIDTH-1:0] last_sector_ff, last_sector_in;
   logic                             reg_sel;
   bmh_pkg::cmd_type                 cmd;
   bmh_pkg::status_type              status;

   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[bmh_pkg::CSR_ADDR_WIDTH-1:2]
                        == (bmh_pkg::CSR_ADDR_WIDTH - 2)'(bmh_pkg::CFG_REG_LAST_SECTOR));

   always_comb begin
      last_sector_in = last_sector_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel) begin
         last_sector_in = csr_pwdata[bmh_pkg::SECTOR_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sector_ff <= bmh_pkg::SECTOR_WIDTH'(bmh_pkg::LAST_SECTOR_RESET);
      end else begin
         last_sector_ff <= last_sector_in;
      end
   end

   assign csr_prdata = reg_sel ? bmh_pkg::CSR_DATA_WIDTH'(last_sector_ff) : '0;

   bmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bmh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .last_sector (last_sector_ff),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== tb/binned_mass_histogram_unit_tb.sv =====
// binned_mass_histogram_unit_tb: self-checking bench for the binned mass histogram.
// Directed table, then random fill/read items with a local histogram predictor.
// Depends on bmh_pkg and binned_mass_histogram_unit.
`timescale 1ns / 100ps

module binned_mass_histogram_unit_tb;
   import bmh_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 375;
   localparam int PHASE_COUNT  = 5;
   localparam int IDLE_PERCENT = 37;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   req_type                     req_data;
   logic                        rsp_valid;
   logic                        rsp_ready;
   rsp_type                     rsp_data;
   logic                        csr_psel;
   logic                        csr_penable;
   logic                        csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0]   csr_paddr;
   logic [CSR_DATA_WIDTH-1:0]   csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0]   csr_prdata;
   logic                        csr_pready;

   logic [COUNT_WIDTH-1:0]  model_counts [2][PT_BIN_COUNT][MASS_SLOTS];
   logic [SECTOR_WIDTH-1:0] last_sector_cfg;
   rsp_type                 expected_bins [$];
   dir_row_type             dir_rows [$];
   bit                      idle_on;
   int                      fail_count;
   int                      stall_cycles;

   binned_mass_histogram_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_type make_rsp(input logic counted, input logic [COUNT_WIDTH-1:0] cnt,
                                        input logic cls, input logic [PT_BIN_WIDTH-1:0] ptb,
                                        input logic [MASS_BIN_WIDTH-1:0] mb);
      rsp_type r;
      r.counted      = counted;
      r.bin_count    = cnt;
      r.class_out    = cls;
      r.pt_bin_out   = ptb;
      r.mass_bin_out = mb;
      return r;
   endfunction

   function automatic req_type fill_req(input int pt, input int mass, input int sector,
                                        input logic fired);
      req_type r;
      r                = '0;
      r.command        = CMD_FILL;
      r.pt_mev         = pt[PT_WIDTH-1:0];
      r.mass_mev       = mass[MASS_WIDTH-1:0];
      r.sector         = sector[SECTOR_WIDTH-1:0];
      r.min_bias_fired = fired;
      return r;
   endfunction

   function automatic req_type read_req(input logic cls, input int ptb, input int mb);
      req_type r;
      r               = '0;
      r.command       = CMD_READ;
      r.read_class    = cls;
      r.read_pt_bin   = ptb[PT_BIN_WIDTH-1:0];
      r.read_mass_bin = mb[MASS_BIN_WIDTH-1:0];
      return r;
   endfunction

   // histogram predictor: returns the result and updates the local counters
   function automatic rsp_type predict_bin(input req_type it);
      int   ptb;
      int   mb;
      logic cls;
      if (it.command == CMD_READ) begin
         if (it.read_pt_bin < PT_BIN_COUNT && it.read_mass_bin <= MASS_BIN_COUNT)
            return make_rsp(1'b0,
                            model_counts[it.read_class][it.read_pt_bin][it.read_mass_bin],
                            it.read_class, it.read_pt_bin, it.read_mass_bin);
         return make_rsp(1'b0, '0, it.read_class, it.read_pt_bin, it.read_mass_bin);
      end
      if (!it.min_bias_fired || it.pt_mev < PT_LOW_MEV || it.pt_mev >= PT_HIGH_MEV)
         return make_rsp(1'b0, '0, 1'b0, '0, '0);
      cls = (it.sector <= last_sector_cfg) ? 1'b0 : 1'b1;
      ptb = (int'(it.pt_mev) - PT_LOW_MEV) / PT_STEP_MEV;
      mb  = (it.mass_mev < MASS_LIMIT_MEV) ? int'(it.mass_mev) / MASS_STEP_MEV
                                           : MASS_BIN_COUNT;
      if (model_counts[cls][ptb][mb] != '1) begin
         model_counts[cls][ptb][mb] = model_counts[cls][ptb][mb] + 1'b1;
         return make_rsp(1'b1, model_counts[cls][ptb][mb], cls, ptb[PT_BIN_WIDTH-1:0],
                         mb[MASS_BIN_WIDTH-1:0]);
      end
      return make_rsp(1'b0, model_counts[cls][ptb][mb], cls, ptb[PT_BIN_WIDTH-1:0],
                      mb[MASS_BIN_WIDTH-1:0]);
   endfunction

   // mostly accepted fills, some reads, some noise; a hot corner keeps counts growing
   function automatic req_type random_item();
      req_type r;
      int      pick;
      bit      hot;
      r    = req_type'($bits(req_type)'({$urandom, $urandom}));
      pick = $urandom_range(99);
      hot  = ($urandom_range(99) < 30);
      if (pick < 60) begin
         r.command        = CMD_FILL;
         r.min_bias_fired = 1'b1;
         r.pt_mev         = PT_WIDTH'(hot ? $urandom_range(PT_LOW_MEV, PT_LOW_MEV + 999)
                                          : $urandom_range(PT_LOW_MEV, PT_HIGH_MEV - 1));
         case ($urandom_range(3))
            0: r.mass_mev = MASS_WIDTH'($urandom_range(0, 89));
            1: r.mass_mev = MASS_WIDTH'($urandom_range(MASS_LIMIT_MEV, 65535));
            default: r.mass_mev = MASS_WIDTH'(hot ? $urandom_range(0, 89)
                                                  : $urandom_range(0, MASS_LIMIT_MEV - 1));
         endcase
      end else if (pick < 82) begin
         r.command = CMD_READ;
         if ($urandom_range(99) < 85) begin
            r.read_pt_bin   = PT_BIN_WIDTH'(hot ? $urandom_range(0, 1)
                                                : $urandom_range(0, PT_BIN_COUNT - 1));
            r.read_mass_bin = MASS_BIN_WIDTH'(hot ? $urandom_range(0, 2)
                                                  : $urandom_range(0, MASS_BIN_COUNT));
         end
      end else begin
         r.command = CMD_FILL;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic send_item(input req_type it, input bit typed, input rsp_type want);
      rsp_type predicted;
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = predict_bin(it);
      expected_bins.push_back(typed ? want : predicted);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_bins.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_last_sector(input logic [SECTOR_WIDTH-1:0] value);
      logic [CSR_DATA_WIDTH-1:0] want;
      want        = CSR_DATA_WIDTH'(value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(CFG_REG_LAST_SECTOR * 4);
      csr_pwdata  <= want;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      last_sector_cfg = value;
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field("first_class_last_sector", want, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   always @(negedge clock)
      rsp_ready <= !idle_on || ($urandom_range(99) >= IDLE_PERCENT);

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bins.size() == 0) begin
            $error("result item with no expectation waiting");
            fail_count++;
         end else begin
            want = expected_bins.pop_front();
            check_field("counted", want.counted, rsp_data.counted);
            check_field("bin_count", want.bin_count, rsp_data.bin_count);
            check_field("class_out", want.class_out, rsp_data.class_out);
            check_field("pt_bin_out", want.pt_bin_out, rsp_data.pt_bin_out);
            check_field("mass_bin_out", want.mass_bin_out, rsp_data.mass_bin_out);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      idle_on         = 1'b1;
      fail_count      = 0;
      last_sector_cfg = SECTOR_WIDTH'(LAST_SECTOR_RESET);
      foreach (model_counts[c, p, m]) model_counts[c][p][m] = '0;

      dir_rows.push_back('{read_req(0, 0, 0), 1'b1, make_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{read_req(1, 10, 50), 1'b1, make_rsp(0, 0, 1, 10, 50)});
      dir_rows.push_back('{read_req(0, 15, 63), 1'b1, make_rsp(0, 0, 0, 15, 63)});
      dir_rows.push_back('{read_req(1, 11, 0), 1'b1, make_rsp(0, 0, 1, 11, 0)});
      dir_rows.push_back('{read_req(0, 0, 51), 1'b1, make_rsp(0, 0, 0, 0, 51)});
      dir_rows.push_back('{fill_req(3000, 100, 0, 0), 1'b1, make_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{fill_req(2499, 100, 0, 1), 1'b1, make_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{fill_req(8000, 100, 0, 1), 1'b1, make_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{fill_req(0, 0, 0, 1), 1'b1, make_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{fill_req(65535, 65535, 7, 1), 1'b1, make_rsp(0, 0, 0, 0, 0)});
      dir_rows.push_back('{fill_req(2500, 0, 0, 1), 1'b1, make_rsp(1, 1, 0, 0, 0)});
      dir_rows.push_back('{fill_req(7999, 1499, 7, 1), 1'b1, make_rsp(1, 1, 1, 10, 49)});
      dir_rows.push_back('{fill_req(7999, 1500, 6, 1), 1'b1, make_rsp(1, 1, 1, 10, 50)});
      dir_rows.push_back('{fill_req(2500, 65535, 5, 1), 1'b1, make_rsp(1, 1, 0, 0, 50)});
      dir_rows.push_back('{fill_req(2999, 29, 0, 1), 1'b0, '0});
      dir_rows.push_back('{fill_req(3000, 30, 6, 1), 1'b0, '0});
      dir_rows.push_back('{read_req(0, 0, 0), 1'b0, '0});
      dir_rows.push_back('{read_req(1, 10, 50), 1'b0, '0});
      dir_rows.push_back('{fill_req(5499, 1529, 4, 1), 1'b0, '0});
      dir_rows.push_back('{read_req(0, 5, 50), 1'b0, '0});

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_for_results();
         case (phase)
            0: write_last_sector('0);
            1: write_last_sector('1);
            default: write_last_sector(SECTOR_WIDTH'($urandom_range(0, 7)));
         endcase
         idle_on = (phase != 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == PHASE_ITEMS / 2) wait_for_results();
            send_item(random_item(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bmh_pkg.sv
sv/bmh_ram.sv
sv/bmh_ctrl.sv
sv/bmh_datapath.sv
sv/binned_mass_histogram_unit.sv
tb/binned_mass_histogram_unit_tb.sv
